>>> hdl/dvrt_pkg.sv
// Shared types, codes and constants of the distance-vector route table.
package dvrt_pkg;

   // Default number of table entries.
   localparam int ROUTES_DEF = 32;

   // Field widths.
   localparam int ADDR_W   = 32;
   localparam int METRIC_W = 5;
   localparam int AGE_W    = 5;

   // Metric that marks an unreachable route, and the age past which a route expires.
   localparam logic [METRIC_W-1:0]      UNREACHABLE = 5'd16;
   localparam logic [METRIC_W-1:0]      LAST_HOP    = 5'd15;
   localparam logic signed [AGE_W-1:0]  EXPIRE_AGE  = 5'sd10;
   localparam logic signed [AGE_W-1:0]  AGE_STATIC  = -5'sd1;
   localparam logic signed [AGE_W-1:0]  AGE_FRESH   = 5'sd0;
   localparam logic signed [AGE_W-1:0]  AGE_HOLD    = 5'sd1;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 2 * ADDR_W - METRIC_W;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Input operation codes.
   typedef enum logic {
      OP_INSTALL = 1'b0,
      OP_TICK    = 1'b1
   } op_type;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_INSTALL = 2'd0,
      KIND_DELETE  = 2'd1,
      KIND_ADVERT  = 2'd2,
      KIND_FULL    = 2'd3
   } kind_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_TICK_A,
      ST_TICK_B,
      ST_FINISH
   } state_type;

   // One table entry as it is stored in the route memory.
   typedef struct packed {
      logic [ADDR_W-1:0]        destination;
      logic [ADDR_W-1:0]        gateway;
      logic [METRIC_W-1:0]      metric;
      logic signed [AGE_W-1:0]  age;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // One result beat.
   typedef struct packed {
      kind_type                 kind;
      logic [ADDR_W-1:0]        destination;
      logic [ADDR_W-1:0]        gateway;
      logic [METRIC_W-1:0]      metric;
   } result_type;

endpackage

>>> hdl/dvrt_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module dvrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data register holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/distance_vector_route_table.sv
// Distance-vector route table. The routes live in one memory of ROUTES entries that is
// walked one entry per cycle unless the result side holds off a beat: an install beat
// with a reachable metric scans the whole table for a matching or free slot and then
// makes the decision and write-back in a state of its own; a tick beat makes two passes
// (age fix and advertisements, then expiry and aging). The single read port of the route
// memory paces these sweeps. One item is worked on at a time; req_tready is high only
// between items. The last result beat of an item carries rsp_tlast. Reset empties the
// table at once through per-entry valid bits, so no clearing pass follows reset.
module distance_vector_route_table #(
   parameter int ROUTES = dvrt_pkg::ROUTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request stream.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: destination[31:0], gateway[63:32], metric[68:64], static_route[69], zeros
   input  logic [dvrt_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // tuser: op[0]
   input  logic [0:0]                         req_tuser,
   // Result stream.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: route_destination[31:0], route_gateway[63:32], route_metric[68:64], zeros
   output logic [dvrt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // tuser: kind[1:0]
   output logic [1:0]                         rsp_tuser,
   output logic                               rsp_tlast,
   // Configuration port.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dvrt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dvrt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dvrt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import dvrt_pkg::*;

   localparam int IDX_W = $clog2(ROUTES);
   localparam int CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(ROUTES);

   // Sequencer and current item.
   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         cur_dst_ff, cur_dst_in;
   logic [ADDR_W-1:0]         cur_gw_ff, cur_gw_in;
   logic [METRIC_W-1:0]       cur_met_ff, cur_met_in;
   logic signed [AGE_W-1:0]   cur_age_ff, cur_age_in;
   logic                      suppress_ff, suppress_in;

   // Sweep: read counter and the stage that holds the entry read most recently.
   logic [CNT_W-1:0]          rd_cnt_ff, rd_cnt_in;
   logic                      p_vld_ff, p_vld_in;
   logic [IDX_W-1:0]          p_idx_ff, p_idx_in;
   logic                      p_live_ff, p_live_in;

   // Slot found by the install scan.
   logic                      have_match_ff, have_match_in;
   logic                      have_spare_ff, have_spare_in;
   logic [IDX_W-1:0]          slot_ff, slot_in;
   entry_type                 slot_data_ff, slot_data_in;

   // Entry valid bits; an entry never written reads as empty.
   logic [ROUTES-1:0]         valid_ff, valid_in;

   // Result path: a holding stage that keeps the newest result until the item's
   // end is known, and the output register.
   logic                      hold_vld_ff, hold_vld_in;
   result_type                hold_ff, hold_in;
   logic                      out_vld_ff, out_vld_in;
   result_type                out_ff, out_in;
   logic                      out_last_ff, out_last_in;

   // Memory ports.
   logic                      ram_we;
   logic [IDX_W-1:0]          ram_waddr;
   entry_type                 ram_wdata;
   logic                      ram_re;
   logic [IDX_W-1:0]          ram_raddr;
   logic [ENTRY_W-1:0]        ram_rdata;

   // Combinational helpers.
   entry_type                 rd_entry;
   logic                      out_free;
   logic                      can_push;
   logic                      emit;
   result_type                emit_data;
   logic                      want_emit;
   logic                      stall;
   logic                      sweeping;
   logic [METRIC_W-1:0]       in_met;
   logic [METRIC_W-1:0]       new_met;
   logic                      used;
   logic                      csr_wr;
   logic                      csr_hit;

   dvrt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ROUTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // The entry under work; a never written entry reads as all zeros.
   assign rd_entry = p_live_ff ? entry_type'(ram_rdata) : '0;
   assign used     = (rd_entry.destination != '0);
   assign new_met  = (used && (rd_entry.age > AGE_FRESH) && (rd_entry.metric < UNREACHABLE))
                     ? LAST_HOP : rd_entry.metric;

   assign out_free = !out_vld_ff || rsp_tready;
   assign can_push = !hold_vld_ff || out_free;
   assign in_met   = (req_tdata[68:64] > UNREACHABLE) ? UNREACHABLE : req_tdata[68:64];
   assign sweeping = (state_ff == ST_SCAN) || (state_ff == ST_TICK_A) ||
                     (state_ff == ST_TICK_B);

   // Whether the entry under work produces a result in this pass.
   always_comb begin
      want_emit = 1'b0;
      case (state_ff)
         ST_TICK_A: want_emit = used && !suppress_ff && (new_met < UNREACHABLE);
         ST_TICK_B: want_emit = used && (rd_entry.age > EXPIRE_AGE) &&
                                (rd_entry.gateway != rd_entry.destination);
         default:   want_emit = 1'b0;
      endcase
   end

   assign stall = p_vld_ff && want_emit && !can_push;

   // Configuration access.
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == 1'b0);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-1){1'b0}}, suppress_ff} : '0;
   assign suppress_in = (csr_wr && csr_hit) ? csr_pwdata[0] : suppress_ff;

   // Next state and outputs of the sequencer.
   always_comb begin
      state_in      = state_ff;
      cur_dst_in    = cur_dst_ff;
      cur_gw_in     = cur_gw_ff;
      cur_met_in    = cur_met_ff;
      cur_age_in    = cur_age_ff;
      rd_cnt_in     = rd_cnt_ff;
      p_vld_in      = p_vld_ff;
      p_idx_in      = p_idx_ff;
      p_live_in     = p_live_ff;
      have_match_in = have_match_ff;
      have_spare_in = have_spare_ff;
      slot_in       = slot_ff;
      slot_data_in  = slot_data_ff;
      valid_in      = valid_ff;
      hold_vld_in   = hold_vld_ff;
      hold_in       = hold_ff;
      out_vld_in    = out_vld_ff && !rsp_tready;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = p_idx_ff;
      ram_wdata     = rd_entry;
      ram_re        = 1'b0;
      ram_raddr     = rd_cnt_ff[IDX_W-1:0];
      emit          = 1'b0;
      emit_data     = '0;
      req_tready    = (state_ff == ST_IDLE);

      case (state_ff)
         // Take a new item.
         ST_IDLE: begin
            if (req_tvalid) begin
               cur_dst_in    = req_tdata[31:0];
               cur_gw_in     = req_tdata[63:32];
               cur_met_in    = in_met;
               cur_age_in    = req_tdata[69] ? AGE_STATIC : AGE_FRESH;
               rd_cnt_in     = '0;
               p_vld_in      = 1'b0;
               have_match_in = 1'b0;
               have_spare_in = 1'b0;
               if (op_type'(req_tuser[0]) == OP_TICK) begin
                  state_in = ST_TICK_A;
               end else if (in_met >= UNREACHABLE) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end

         // Install: report a full table when no slot was found, else write the offer back when it is taken.
         ST_DECIDE: begin
            state_in = ST_FINISH;
            if (!have_match_ff && !have_spare_ff) begin
               emit      = 1'b1;
               emit_data = '{kind: KIND_FULL, destination: cur_dst_ff,
                             gateway: cur_gw_ff, metric: cur_met_ff};
            end else if (!((cur_gw_ff != slot_data_ff.gateway) &&
                           (slot_data_ff.age > AGE_HOLD))) begin
               if ((slot_data_ff.destination == '0) ||
                   (cur_met_ff < slot_data_ff.metric) ||
                   ((cur_gw_ff == slot_data_ff.gateway) &&
                    ((cur_met_ff != slot_data_ff.metric) ||
                     (cur_age_ff != slot_data_ff.age)))) begin
                  ram_we            = 1'b1;
                  ram_waddr         = slot_ff;
                  ram_wdata         = '{destination: cur_dst_ff, gateway: cur_gw_ff,
                                        metric: cur_met_ff, age: cur_age_ff};
                  valid_in[slot_ff] = 1'b1;
                  if ((cur_dst_ff != cur_gw_ff) &&
                      ((slot_data_ff.destination != cur_dst_ff) ||
                       (slot_data_ff.gateway != cur_gw_ff))) begin
                     emit      = 1'b1;
                     emit_data = '{kind: KIND_INSTALL, destination: cur_dst_ff,
                                   gateway: cur_gw_ff, metric: cur_met_ff};
                  end
               end
            end
         end

         // Flush the held result as the item's final beat.
         ST_FINISH: begin
            if (!hold_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in      = hold_ff;
               out_last_in = 1'b1;
               out_vld_in  = 1'b1;
               hold_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
         end
      endcase

      // Entry sweeps: work on the entry read most recently while reading the next one.
      if (sweeping && !stall) begin
         if (p_vld_ff) begin
            case (state_ff)
               ST_SCAN: begin
                  if (!have_match_ff) begin
                     if (rd_entry.destination == cur_dst_ff) begin
                        have_match_in = 1'b1;
                        slot_in       = p_idx_ff;
                        slot_data_in  = rd_entry;
                     end else if (!used && !have_spare_ff) begin
                        have_spare_in = 1'b1;
                        slot_in       = p_idx_ff;
                        slot_data_in  = rd_entry;
                     end
                  end
               end
               ST_TICK_A: begin
                  if (used) begin
                     ram_we           = 1'b1;
                     ram_wdata.metric = new_met;
                     valid_in[p_idx_ff] = 1'b1;
                  end
                  if (want_emit) begin
                     emit      = 1'b1;
                     emit_data = '{kind: KIND_ADVERT, destination: rd_entry.destination,
                                   gateway: '0, metric: new_met + 5'd1};
                  end
               end
               ST_TICK_B: begin
                  if (used) begin
                     if (rd_entry.age > EXPIRE_AGE) begin
                        ram_we             = 1'b1;
                        ram_wdata          = '0;
                        valid_in[p_idx_ff] = 1'b1;
                        if (want_emit) begin
                           emit      = 1'b1;
                           emit_data = '{kind: KIND_DELETE,
                                         destination: rd_entry.destination,
                                         gateway: '0, metric: rd_entry.metric};
                        end
                     end else if (rd_entry.age >= AGE_FRESH) begin
                        ram_we             = 1'b1;
                        ram_wdata.age      = rd_entry.age + 5'sd1;
                        valid_in[p_idx_ff] = 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end

         // Issue the next read, or close the pass once the last entry is done.
         if (rd_cnt_ff < CNT_END) begin
            ram_re    = 1'b1;
            p_vld_in  = 1'b1;
            p_idx_in  = rd_cnt_ff[IDX_W-1:0];
            p_live_in = valid_ff[rd_cnt_ff[IDX_W-1:0]];
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
         end else begin
            p_vld_in = 1'b0;
            if (!p_vld_ff) begin
               rd_cnt_in = '0;
               case (state_ff)
                  ST_SCAN:   state_in = ST_DECIDE;
                  ST_TICK_A: state_in = ST_TICK_B;
                  default:   state_in = ST_FINISH;
               endcase
            end
         end
      end

      // A new result pushes the held one out as a non-final beat.
      if (emit) begin
         if (hold_vld_ff) begin
            out_in      = hold_ff;
            out_last_in = 1'b0;
            out_vld_in  = 1'b1;
         end
         hold_in     = emit_data;
         hold_vld_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         suppress_ff <= 1'b0;
         valid_ff    <= '0;
         rd_cnt_ff   <= '0;
         p_vld_ff    <= 1'b0;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         suppress_ff <= suppress_in;
         valid_ff    <= valid_in;
         rd_cnt_ff   <= rd_cnt_in;
         p_vld_ff    <= p_vld_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_dst_ff    <= cur_dst_in;
      cur_gw_ff     <= cur_gw_in;
      cur_met_ff    <= cur_met_in;
      cur_age_ff    <= cur_age_in;
      p_idx_ff      <= p_idx_in;
      p_live_ff     <= p_live_in;
      have_match_ff <= have_match_in;
      have_spare_ff <= have_spare_in;
      slot_ff       <= slot_in;
      slot_data_ff  <= slot_data_in;
      hold_ff       <= hold_in;
      out_ff        <= out_in;
      out_last_ff   <= out_last_in;
   end

   // Result stream.
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_ff.metric, out_ff.gateway, out_ff.destination};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

>>> hdl/dvrt_checker.sv
// Port-level checks of the route table, bound to its top level.
module dvrt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [dvrt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser,
   input logic                             rsp_tlast,
   input logic                             csr_pready
);
   import dvrt_pkg::*;

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result beat changed");

   // An accepted item keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken again right after a beat");

   // Install and table-full results are always marked as the last result of their item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser == KIND_FULL) || (rsp_tuser == KIND_INSTALL))) |-> rsp_tlast)
      else $error("install or table-full result not marked last");

   // While an item still has results to come, no new item is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> !req_tready)
      else $error("request side open before the item's last result");

   // The configuration port never inserts wait states.
   assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port not ready");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);
